// File: hw/rtl/differential_drive_wheel_speeds_core_macros.svh
// Assertion helpers shared by the wheel speed core modules.
`ifndef DIFFERENTIAL_DRIVE_WHEEL_SPEEDS_CORE_MACROS_SVH
`define DIFFERENTIAL_DRIVE_WHEEL_SPEEDS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DDWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define DDWS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define DDWS_ASSERT(lbl, prop, msg)
`define DDWS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// File: hw/rtl/ddws_pkg.sv
`timescale 1ns / 1ps
package ddws_pkg;

  localparam int unsigned OpW     = 3;
  localparam int unsigned ValW    = 16;
  localparam int unsigned CfgW    = 24;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned LenW    = 16;
  localparam int unsigned L2dW    = 24;
  localparam int unsigned LimW    = 7;
  localparam int unsigned SpdW    = 21;
  localparam int unsigned RadW    = 17;
  localparam int unsigned QShift  = 16;
  localparam int unsigned FullW   = 24;
  localparam int unsigned MulAW   = 33;
  localparam int unsigned MulBW   = 24;
  localparam int unsigned MulPW   = MulAW + MulBW;
  localparam int unsigned DivQW   = 24;
  localparam int unsigned DivDW   = RadW;
  localparam int unsigned DivNW   = DivQW + DivDW;
  localparam int unsigned DivCntW = $clog2(DivQW + 1);
  localparam int unsigned PercentFull = 100;

  localparam logic [LenW-1:0] TreadRst = LenW'(150);
  localparam logic [L2dW-1:0] L2dRst   = L2dW'(327680);
  localparam logic [LenW-1:0] TightRst = LenW'(100);
  localparam logic [LenW-1:0] WideRst  = LenW'(5100);
  localparam logic [LimW-1:0] LimitRst = LimW'(100);

  localparam logic [FullW-1:0] SpdMaxMag = FullW'((1 << (SpdW - 1)) - 1);
  localparam logic [FullW-1:0] SpdMinMag = FullW'(1 << (SpdW - 1));

  typedef enum logic [OpW-1:0] {
    OP_SPEED = 3'd0,
    OP_STEER = 3'd1,
    OP_CURVE = 3'd2,
    OP_TURN  = 3'd3,
    OP_STOP  = 3'd4,
    OP_START = 3'd5,
    OP_TICK  = 3'd6
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TREAD = 3'd0,
    CFG_L2D   = 3'd1,
    CFG_TIGHT = 3'd2,
    CFG_WIDE  = 3'd3,
    CFG_LIMIT = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RATE,
    ST_TERM,
    ST_FULL,
    ST_CM1,
    ST_CM2,
    ST_CDIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic signed [SpdW-1:0] sat_speed(input logic neg,
                                                        input logic [FullW-1:0] mag);
    logic signed [SpdW-1:0] res;
    if (!neg) begin
      if (mag > SpdMaxMag) res = $signed({1'b0, {(SpdW - 1){1'b1}}});
      else res = $signed({1'b0, mag[SpdW-2:0]});
    end else begin
      if (mag >= SpdMinMag) res = $signed({1'b1, {(SpdW - 1){1'b0}}});
      else res = -$signed({1'b0, mag[SpdW-2:0]});
    end
    return res;
  endfunction

endpackage

// File: hw/rtl/differential_drive_wheel_speeds_core.sv
`timescale 1ns / 1ps
`include "differential_drive_wheel_speeds_core_macros.svh"
// Channel   | Handshake                  | Payload
// ----------+----------------------------+---------------------------------------
// cfg       | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
// in        | in_valid_i / in_ready_o    | op_i, value_i, brake_req_i
// out       | out_valid_o / out_ready_i  | left_speed_o, right_speed_o, brake_out_o
//
// Commands other than steer and tick complete in ST_IDLE. A steer with nonzero percent
// runs through ST_RATE and ST_TERM, using the 24-step shared divider. A tick on a curve
// makes three passes through the shared multiplier and a 24-step divide.
// Reset loads the register defaults and clears all pending command state.
// A finished result holds in the output register while the next transaction is taken.
module differential_drive_wheel_speeds_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [ddws_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [ddws_pkg::CfgW-1:0]           cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ddws_pkg::OpW-1:0]            op_i,
  input  logic signed [ddws_pkg::ValW-1:0]    value_i,
  input  logic                                brake_req_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ddws_pkg::SpdW-1:0]    left_speed_o,
  output logic signed [ddws_pkg::SpdW-1:0]    right_speed_o,
  output logic                                brake_out_o
);
  import ddws_pkg::*;

  localparam int unsigned SumW = RadW + 2;
  localparam logic signed [SumW-1:0] RadMax = $signed({3'b000, {(RadW - 1){1'b1}}});
  localparam logic signed [SumW-1:0] RadMin = $signed({3'b111, {(RadW - 1){1'b0}}});

  logic [LenW-1:0] tread_q, tight_q, wide_q;
  logic [L2dW-1:0] l2d_q;
  logic [LimW-1:0] limit_q;

  state_e state_q, state_d;

  logic                   pending_q, pending_d;
  logic signed [ValW-1:0] body_q, body_d;
  logic signed [RadW-1:0] radius_q, radius_d;
  logic                   straight_q, straight_d;
  logic signed [ValW-1:0] turn_q, turn_d;
  logic                   brake_q, brake_d;

  logic                   p_neg_q, p_neg_d;
  logic [LimW-1:0]        mag_q, mag_d;
  logic [FullW-1:0]       full_q, full_d;
  logic signed [SpdW-1:0] res_left_q, res_left_d, res_right_q, res_right_d;
  logic                   res_brake_q, res_brake_d;

  logic                   out_valid_q, out_valid_d;
  logic signed [SpdW-1:0] out_left_q, out_left_d, out_right_q, out_right_d;
  logic                   out_brake_q, out_brake_d;

  logic             mul_en;
  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] mul_p;
  div_req_t         div_req;
  div_stat_t        div_stat;
  logic [DivQW-1:0] div_quot;

  logic                   accept;
  logic                   out_free;
  logic                   body_neg;
  logic [ValW-1:0]        body_abs;
  logic [ValW-1:0]        val_abs;
  logic [LimW-1:0]        mag_in;
  logic                   diff_neg;
  logic [LenW-1:0]        diff_mag;
  logic                   over_full;
  logic [LimW-1:0]        hund_mag;
  logic                   term_neg;
  logic [RadW-1:0]        r_abs, r_eff, d_eff;
  logic [FullW-1:0]       full_mag;
  logic signed [SumW-1:0] s_term, s_sum, s_fin;
  logic signed [RadW-1:0] rad_sat;
  logic                   go_direct;

  ddws_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  ddws_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tread_q <= TreadRst;
      l2d_q   <= L2dRst;
      tight_q <= TightRst;
      wide_q  <= WideRst;
      limit_q <= LimitRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TREAD: tread_q <= cfg_wdata_i[LenW-1:0];
        CFG_L2D:   l2d_q   <= cfg_wdata_i[L2dW-1:0];
        CFG_TIGHT: tight_q <= cfg_wdata_i[LenW-1:0];
        CFG_WIDE:  wide_q  <= cfg_wdata_i[LenW-1:0];
        CFG_LIMIT: limit_q <= cfg_wdata_i[LimW-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign body_neg  = body_q[ValW-1];
  assign body_abs  = body_neg ? ValW'(-body_q) : ValW'(body_q);
  assign val_abs   = value_i[ValW-1] ? ValW'(-value_i) : ValW'(value_i);
  assign mag_in    = (val_abs > ValW'(limit_q)) ? limit_q : val_abs[LimW-1:0];
  assign diff_neg  = wide_q < tight_q;
  assign diff_mag  = diff_neg ? tight_q - wide_q : wide_q - tight_q;
  assign over_full = mag_q > LimW'(PercentFull);
  assign hund_mag  = over_full ? mag_q - LimW'(PercentFull) : LimW'(PercentFull) - mag_q;
  assign term_neg  = diff_neg ^ over_full;

  assign r_abs = radius_q[RadW-1] ? RadW'(-radius_q) : RadW'(radius_q);
  assign r_eff = (r_abs < RadW'(tread_q)) ? RadW'(tread_q) : r_abs;
  assign d_eff = r_eff - RadW'(tread_q);

  assign full_mag  = mul_p[FullW+QShift-1:QShift];
  assign go_direct = (turn_q != '0) || straight_q || (radius_q == '0);

  assign s_term = term_neg ? -$signed({2'b00, mul_p[RadW-1:0]})
                           :  $signed({2'b00, mul_p[RadW-1:0]});
  assign s_sum  = $signed({3'b000, tight_q}) + s_term;
  assign s_fin  = p_neg_q ? -s_sum : s_sum;

  always_comb begin
    if (s_fin > RadMax) rad_sat = RadMax[RadW-1:0];
    else if (s_fin < RadMin) rad_sat = RadMin[RadW-1:0];
    else rad_sat = s_fin[RadW-1:0];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_STEER && mag_in != '0) state_d = ST_RATE;
          else if (op_i == OP_TICK && pending_q) begin
            state_d = (body_q == '0) ? ST_OUT : ST_FULL;
          end
        end
      end
      ST_RATE: if (div_stat.done) state_d = ST_TERM;
      ST_TERM: state_d = ST_IDLE;
      ST_FULL: state_d = go_direct ? ST_OUT : ST_CM1;
      ST_CM1:  state_d = ST_CM2;
      ST_CM2:  state_d = ST_CDIV;
      ST_CDIV: if (div_stat.done) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pending_d   = pending_q;
    body_d      = body_q;
    radius_d    = radius_q;
    straight_d  = straight_q;
    turn_d      = turn_q;
    brake_d     = brake_q;
    p_neg_d     = p_neg_q;
    mag_d       = mag_q;
    full_d      = full_q;
    res_left_d  = res_left_q;
    res_right_d = res_right_q;
    res_brake_d = res_brake_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_left_d  = out_left_q;
    out_right_d = out_right_q;
    out_brake_d = out_brake_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_req     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op_i)
            OP_SPEED: begin
              body_d    = value_i;
              pending_d = 1'b1;
            end
            OP_STEER: begin
              pending_d = 1'b1;
              if (mag_in == '0) begin
                straight_d = 1'b1;
                radius_d   = '0;
              end else begin
                p_neg_d          = value_i[ValW-1];
                mag_d            = mag_in;
                div_req.start    = 1'b1;
                div_req.dividend = DivNW'(diff_mag);
                div_req.divisor  = DivDW'(PercentFull);
              end
            end
            OP_CURVE: begin
              radius_d   = {value_i[ValW-1], value_i};
              straight_d = 1'b0;
              pending_d  = 1'b1;
            end
            OP_TURN: begin
              turn_d     = value_i;
              radius_d   = '0;
              straight_d = 1'b0;
              pending_d  = 1'b1;
            end
            OP_STOP: begin
              brake_d   = brake_req_i;
              turn_d    = '0;
              body_d    = '0;
              pending_d = 1'b1;
            end
            OP_START: pending_d = 1'b1;
            OP_TICK: begin
              if (pending_q) begin
                if (body_q == '0) begin
                  res_left_d  = '0;
                  res_right_d = '0;
                  res_brake_d = brake_q;
                end else begin
                  mul_en = 1'b1;
                  mul_a  = MulAW'(body_abs);
                  mul_b  = l2d_q;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RATE: begin
        if (div_stat.done) begin
          mul_en = 1'b1;
          mul_a  = MulAW'(div_quot);
          mul_b  = MulBW'(hund_mag);
        end
      end
      ST_TERM: begin
        radius_d   = rad_sat;
        straight_d = 1'b0;
      end
      ST_FULL: begin
        full_d      = full_mag;
        res_brake_d = 1'b0;
        if (turn_q != '0) begin
          res_left_d  = sat_speed(body_neg ^ turn_q[ValW-1], full_mag);
          res_right_d = sat_speed(!(body_neg ^ turn_q[ValW-1]), full_mag);
        end else if (go_direct) begin
          res_left_d  = sat_speed(body_neg, full_mag);
          res_right_d = sat_speed(body_neg, full_mag);
        end else begin
          mul_en = 1'b1;
          mul_a  = MulAW'(d_eff);
          mul_b  = MulBW'(body_abs);
        end
      end
      ST_CM1: begin
        mul_en = 1'b1;
        mul_a  = mul_p[MulAW-1:0];
        mul_b  = l2d_q;
      end
      ST_CM2: begin
        div_req.start    = 1'b1;
        div_req.dividend = mul_p[DivNW+QShift-1:QShift];
        div_req.divisor  = r_eff;
      end
      ST_CDIV: begin
        if (div_stat.done) begin
          if (radius_q[RadW-1]) begin
            res_left_d  = sat_speed(body_neg, div_quot);
            res_right_d = sat_speed(body_neg, full_q);
          end else begin
            res_left_d  = sat_speed(body_neg, full_q);
            res_right_d = sat_speed(body_neg, div_quot);
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_left_d  = res_left_q;
          out_right_d = res_right_q;
          out_brake_d = res_brake_q;
          pending_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= 1'b0;
      body_q      <= '0;
      radius_q    <= '0;
      straight_q  <= 1'b1;
      turn_q      <= '0;
      brake_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      body_q      <= body_d;
      radius_q    <= radius_d;
      straight_q  <= straight_d;
      turn_q      <= turn_d;
      brake_q     <= brake_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_neg_q     <= p_neg_d;
    mag_q       <= mag_d;
    full_q      <= full_d;
    res_left_q  <= res_left_d;
    res_right_q <= res_right_d;
    res_brake_q <= res_brake_d;
    out_left_q  <= out_left_d;
    out_right_q <= out_right_d;
    out_brake_q <= out_brake_d;
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = out_left_q;
  assign right_speed_o = out_right_q;
  assign brake_out_o   = out_brake_q;

  `DDWS_ASSERT(a_div_start_state, div_req.start |-> (state_q == ST_IDLE || state_q == ST_CM2), "divider started out of sequence")
  `DDWS_ASSERT(a_out_hold, (state_q == ST_OUT && !out_free) |=> state_q == ST_OUT, "result dropped while output busy")
  `DDWS_ASSERT(a_brake_zero, (out_valid_q && out_brake_q) |-> (out_left_q == '0 && out_right_q == '0), "brake with nonzero speed")
  `DDWS_ASSERT(a_pending_clear, (state_q == ST_OUT && out_free) |=> !pending_q && out_valid_q, "pending not cleared on result")
endmodule

// File: hw/rtl/ddws_div.sv
`timescale 1ns / 1ps
`include "differential_drive_wheel_speeds_core_macros.svh"
module ddws_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ddws_pkg::div_req_t         req_i,
  output ddws_pkg::div_stat_t        stat_o,
  output logic [ddws_pkg::DivQW-1:0] quot_o
);
  import ddws_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivDW-1:0]   rem_q, rem_d;
  logic [DivQW-1:0]   qs_q, qs_d;
  logic [DivDW-1:0]   dvs_q, dvs_d;
  logic [DivDW:0]     trial;
  logic               fits;

  assign trial = {rem_q, qs_q[DivQW-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    qs_d   = qs_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivQW);
      rem_d  = req_i.dividend[DivNW-1:DivQW];
      qs_d   = req_i.dividend[DivQW-1:0];
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = fits ? DivDW'(trial - {1'b0, dvs_q}) : trial[DivDW-1:0];
      qs_d  = {qs_q[DivQW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qs_q  <= qs_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = qs_q;

  `DDWS_ASSERT_NEVER(a_div_restart, req_i.start && busy_q, "divider restarted while busy")
  `DDWS_ASSERT(a_div_done_follows, done_q |-> $past(busy_q) && !busy_q, "done without run")
  `DDWS_ASSERT(a_div_rem_bound, busy_q |-> rem_q < dvs_q, "partial remainder out of range")
endmodule

// File: hw/rtl/ddws_mul.sv
`timescale 1ns / 1ps
module ddws_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [ddws_pkg::MulAW-1:0] a_i,
  input  logic [ddws_pkg::MulBW-1:0] b_i,
  output logic [ddws_pkg::MulPW-1:0] p_o
);
  import ddws_pkg::*;

  logic [MulPW-1:0] p_q, p_d;

  assign p_d = en_i ? a_i * b_i : p_q;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;
endmodule

// File: bench/tb_differential_drive_wheel_speeds_core.sv
`timescale 1ns / 1ps
module tb_differential_drive_wheel_speeds_core;
  import ddws_pkg::*;

  localparam logic [OpW-1:0] OP_NONE = 3'd7;
  localparam longint WheelMax = 1048575;
  localparam longint WheelMin = -1048576;
  localparam longint QOne = 65536;
  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 64;
  localparam int ItemsPerPhase = 118;
  localparam int NumPhases = 6;
  localparam int NumRows = 25;

  typedef struct packed {
    logic signed [SpdW-1:0] left;
    logic signed [SpdW-1:0] right;
    logic                   brake;
  } wheel_res_t;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic signed [ValW-1:0] val;
    logic                   brk;
    logic                   typed;
    wheel_res_t             res;
  } cmd_row_t;

  localparam cmd_row_t DirRows [NumRows] = '{
    '{OP_TICK,  16'sd0,      1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_NONE,  16'sh7fff,   1'b1, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_START, 16'sd0,      1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b1, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_STOP,  16'sd0,      1'b1, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b1, '{21'sd0, 21'sd0, 1'b1}},
    '{OP_SPEED, 16'sh7fff,   1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b1, '{21'sd163835, 21'sd163835, 1'b0}},
    '{OP_SPEED, 16'sh8000,   1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b1, '{-21'sd163840, -21'sd163840, 1'b0}},
    '{OP_TURN,  16'sd1,      1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b1, '{-21'sd163840, 21'sd163840, 1'b0}},
    '{OP_TURN,  16'sh8000,   1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b1, '{21'sd163840, -21'sd163840, 1'b0}},
    '{OP_STOP,  16'sd0,      1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_SPEED, 16'sd1000,   1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_CURVE, 16'sd0,      1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b1, '{21'sd5000, 21'sd5000, 1'b0}},
    '{OP_CURVE, 16'sd300,    1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b1, '{21'sd5000, 21'sd2500, 1'b0}},
    '{OP_CURVE, 16'sh8000,   1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_STEER, 16'sh8000,   1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_TICK,  16'sd0,      1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}},
    '{OP_STEER, 16'shffff,   1'b0, 1'b0, '{21'sd0, 21'sd0, 1'b0}}
  };

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [CfgW-1:0]        cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [OpW-1:0]         op_i = '0;
  logic signed [ValW-1:0] value_i = '0;
  logic                   brake_req_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [SpdW-1:0] left_speed_o;
  logic signed [SpdW-1:0] right_speed_o;
  logic                   brake_out_o;

  differential_drive_wheel_speeds_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .value_i      (value_i),
    .brake_req_i  (brake_req_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .left_speed_o (left_speed_o),
    .right_speed_o(right_speed_o),
    .brake_out_o  (brake_out_o)
  );

  // drive state mirror
  bit             drive_pending = 1'b0;
  int             body_spd = 0;
  int             radius = 0;
  bit             straight = 1'b1;
  int             spin_req = 0;
  bit             brake_sel = 1'b0;
  logic [LenW-1:0] tread = TreadRst;
  logic [L2dW-1:0] l2d = L2dRst;
  logic [LenW-1:0] tight_r = TightRst;
  logic [LenW-1:0] wide_r = WideRst;
  logic [LimW-1:0] steer_lim = LimitRst;

  wheel_res_t wheel_q[$];
  wheel_res_t seen_res;
  wheel_res_t want_res;
  int         mismatches = 0;
  int         cycles = 0;
  int         rdy_hold = 0;
  bit         calm = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint clamp_wheel(input longint v);
    if (v > WheelMax) return WheelMax;
    if (v < WheelMin) return WheelMin;
    return v;
  endfunction

  function automatic bit wheel_step(input logic [OpW-1:0] op, input logic signed [ValW-1:0] val,
                                    input logic brk, output wheel_res_t res);
    longint full, lft, rgt, r, inner, lim, p, rate, mag, s;
    res = '0;
    case (op)
      OP_SPEED: begin
        body_spd = val;
        drive_pending = 1'b1;
      end
      OP_STEER: begin
        lim = steer_lim;
        p = val;
        if (p > lim) p = lim;
        if (p < -lim) p = -lim;
        if (p == 0) begin
          straight = 1'b1;
          radius = 0;
        end else begin
          rate = (longint'(wide_r) - longint'(tight_r)) / 100;
          mag = (p < 0) ? -p : p;
          s = longint'(tight_r) + rate * (100 - mag);
          if (p < 0) s = -s;
          if (s > 65535) s = 65535;
          if (s < -65536) s = -65536;
          radius = int'(s);
          straight = 1'b0;
        end
        drive_pending = 1'b1;
      end
      OP_CURVE: begin
        radius = val;
        straight = 1'b0;
        drive_pending = 1'b1;
      end
      OP_TURN: begin
        spin_req = val;
        radius = 0;
        straight = 1'b0;
        drive_pending = 1'b1;
      end
      OP_STOP: begin
        brake_sel = brk;
        spin_req = 0;
        body_spd = 0;
        drive_pending = 1'b1;
      end
      OP_START: drive_pending = 1'b1;
      OP_TICK: begin
        if (!drive_pending) return 1'b0;
        full = (longint'(body_spd) * longint'(l2d)) / QOne;
        if (body_spd == 0) begin
          lft = 0;
          rgt = 0;
          res.brake = brake_sel;
        end else if (spin_req != 0) begin
          lft = clamp_wheel((spin_req > 0) ? full : -full);
          rgt = clamp_wheel((spin_req > 0) ? -full : full);
        end else if (straight || radius == 0) begin
          lft = clamp_wheel(full);
          rgt = lft;
        end else begin
          r = (radius < 0) ? -longint'(radius) : longint'(radius);
          if (r < longint'(tread)) r = tread;
          inner = ((r - longint'(tread)) * longint'(body_spd) * longint'(l2d)) / (r * QOne);
          inner = clamp_wheel(inner);
          if (radius > 0) begin
            lft = clamp_wheel(full);
            rgt = inner;
          end else begin
            lft = inner;
            rgt = clamp_wheel(full);
          end
        end
        res.left = lft[SpdW-1:0];
        res.right = rgt[SpdW-1:0];
        drive_pending = 1'b0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  function automatic logic signed [ValW-1:0] pick_value(input logic [OpW-1:0] op);
    case ($urandom_range(0, 3))
      0: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sd1;
          3: return -16'sd1;
          default: return 16'sd0;
        endcase
      end
      1: return $urandom;
      default: begin
        case (op)
          OP_SPEED: return int'($urandom_range(0, 4000)) - 2000;
          OP_STEER: return int'($urandom_range(0, 240)) - 120;
          OP_CURVE: return int'($urandom_range(0, 1200)) - 600;
          OP_TURN:  return int'($urandom_range(0, 4)) - 2;
          default:  return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CfgW-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_TREAD: tread = data[LenW-1:0];
      CFG_L2D:   l2d = data[L2dW-1:0];
      CFG_TIGHT: tight_r = data[LenW-1:0];
      CFG_WIDE:  wide_r = data[LenW-1:0];
      CFG_LIMIT: steer_lim = data[LimW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int tr, input int factor, input int tg, input int wd,
                              input int lm);
    write_reg(CFG_TREAD, tr);
    write_reg(CFG_L2D, factor);
    write_reg(CFG_TIGHT, tg);
    write_reg(CFG_WIDE, wd);
    write_reg(CFG_LIMIT, lm);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_cmd(input logic [OpW-1:0] op, input logic signed [ValW-1:0] val,
                          input logic brk, input logic typed, input wheel_res_t typed_res);
    int gap;
    wheel_res_t res;
    gap = calm ? 0 : ($urandom_range(0, 1) ? 0 : pick_gap());
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    value_i <= val;
    brake_req_i <= brk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (wheel_step(op, val, brk, res)) wheel_q.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        seen_res.left = left_speed_o;
        seen_res.right = right_speed_o;
        seen_res.brake = brake_out_o;
        if (wheel_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result L=%0d R=%0d B=%0b",
                                  seen_res.left, seen_res.right, seen_res.brake));
        end else begin
          want_res = wheel_q.pop_front();
          if (want_res.left !== seen_res.left || want_res.right !== seen_res.right ||
              want_res.brake !== seen_res.brake) begin
            flag_mismatch($sformatf("exp L=%0d R=%0d B=%0b got L=%0d R=%0d B=%0b",
                                    want_res.left, want_res.right, want_res.brake,
                                    seen_res.left, seen_res.right, seen_res.brake));
          end
        end
      end
      if (rdy_hold > 0) begin
        rdy_hold--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        rdy_hold = pick_gap() - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    logic [OpW-1:0] op;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: set_geometry(150, 327680, 100, 5100, 100);
        1: set_geometry(65535, 24'hffffff, 65535, 65535, 100);
        2: set_geometry(0, 0, 0, 0, 0);
        3: set_geometry(0, 24'hffffff, 0, 65535, 100);
        4: set_geometry(1000, 65536, 60000, 50, 37);
        default: set_geometry($urandom_range(0, 1) ? $urandom_range(0, 2000) : $urandom_range(0, 65535),
                              $urandom_range(0, 24'hffffff), $urandom_range(0, 65535),
                              $urandom_range(0, 65535), $urandom_range(0, 100));
      endcase
      if (ph == 0) begin
        for (int i = 0; i < NumRows; i++)
          send_cmd(DirRows[i].op, DirRows[i].val, DirRows[i].brk, DirRows[i].typed,
                   DirRows[i].res);
      end
      sent = 0;
      while (sent < ItemsPerPhase) begin
        if ($urandom_range(0, 39) == 0) calm = !calm;
        if ($urandom_range(0, 4) != 0) begin
          n = $urandom_range(1, 3);
          repeat (n) begin
            op = $urandom_range(OP_SPEED, OP_START);
            send_cmd(op, pick_value(op), $urandom_range(0, 1), 1'b0, '0);
          end
          send_cmd(OP_TICK, $urandom, $urandom_range(0, 1), 1'b0, '0);
          sent += n + 1;
        end else begin
          op = $urandom_range(0, 7);
          send_cmd(op, pick_value(op), $urandom_range(0, 1), 1'b0, '0);
          if (op != OP_NONE) sent++;
        end
      end
      calm = 1'b0;
      drain();
    end
    if (mismatches == 0 && wheel_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/ddws_pkg.sv
hw/rtl/ddws_div.sv
hw/rtl/ddws_mul.sv
hw/rtl/differential_drive_wheel_speeds_core.sv
bench/tb_differential_drive_wheel_speeds_core.sv
